// ===== hw/rtl/kpe_pkg.sv =====
// ----------------------------------------------------------------------------
// kpe_pkg : shared types and constants for the keypad entry block
// Operation codes, entry markers, register indexes, reset values and the
// structs passed between the input stage, the register file and the core.
// ----------------------------------------------------------------------------
package kpe_pkg;

   // default sizes of the PIN and option stores
   localparam int PIN_MAX_DEF    = 10;
   localparam int OPTION_MAX_DEF = 3;

   localparam int REG_W   = 16;  // configuration register width
   localparam int KEY_W   = 8;
   localparam int EL_W    = 16;  // raw elapsed field
   localparam int E_W     = 14;  // clamped elapsed, at most 10000
   localparam int DROP_W  = REG_W + E_W;
   localparam int CSR_A_W = 2;

   typedef enum logic [1:0] {
      OP_KEY   = 2'd0,
      OP_TICK  = 2'd1,
      OP_WAKE  = 2'd2,
      OP_SLEEP = 2'd3
   } op_type;

   typedef enum logic [1:0] {
      MARK_NONE = 2'd0,
      MARK_STAR = 2'd1,
      MARK_HASH = 2'd2
   } mark_type;

   localparam logic [KEY_W-1:0] KEY_STAR = 8'h2A;
   localparam logic [KEY_W-1:0] KEY_HASH = 8'h23;

   localparam logic [EL_W-1:0] ELAPSED_LIMIT = 16'd10000;
   localparam logic [E_W-1:0]  ELAPSED_SUBST = 14'd10;

   // register indexes
   localparam logic [CSR_A_W-1:0] CSR_BACKLIGHT_FULL = 2'd0;
   localparam logic [CSR_A_W-1:0] CSR_FADE_PER_MS    = 2'd1;
   localparam logic [CSR_A_W-1:0] CSR_WAKE_TIME_MS   = 2'd2;

   localparam logic [REG_W-1:0] RST_BACKLIGHT_FULL = 16'd4095;
   localparam logic [REG_W-1:0] RST_FADE_PER_MS    = 16'd4;
   localparam logic [REG_W-1:0] RST_WAKE_TIME_MS   = 16'd5000;

   localparam int REQ_DATA_W = 24;
   localparam int RSP_DATA_W = 152;

   typedef struct packed {
      logic [REG_W-1:0] backlight_full;
      logic [REG_W-1:0] fade_per_ms;
      logic [REG_W-1:0] wake_time_ms;
   } cfg_type;

   // one input beat after the input register
   typedef struct packed {
      op_type             op;
      logic [KEY_W-1:0]   key;
      logic [E_W-1:0]     elapsed;
      logic [DROP_W-1:0]  drop;
   } item_type;

   // result fields, last field in the low bits
   typedef struct packed {
      logic        sleep_clear;
      logic [15:0] awake_left_ms;
      logic [15:0] backlight;
      logic [1:0]  option_count;
      logic [23:0] option_code;
      logic [3:0]  pin_count;
      logic [15:0] pin_tail;
      logic [63:0] pin_head;
      logic [1:0]  entry_mode;
   } result_type;

   localparam int RESULT_W = $bits(result_type);

endpackage

// ===== hw/rtl/kpe_csr.sv =====
// ----------------------------------------------------------------------------
// kpe_csr : configuration registers
// Write-only register file; unknown indexes are dropped.
// ----------------------------------------------------------------------------
module kpe_csr (
   input  logic                         clock,
   input  logic                         reset,
   input  logic                         csr_we,
   input  logic [kpe_pkg::CSR_A_W-1:0]  csr_addr,
   input  logic [kpe_pkg::REG_W-1:0]    csr_wdata,
   output kpe_pkg::cfg_type             cfg
);

   kpe_pkg::cfg_type cfg_ff, cfg_in;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_we) begin
         unique case (csr_addr)
            kpe_pkg::CSR_BACKLIGHT_FULL: cfg_in.backlight_full = csr_wdata;
            kpe_pkg::CSR_FADE_PER_MS:    cfg_in.fade_per_ms    = csr_wdata;
            kpe_pkg::CSR_WAKE_TIME_MS:   cfg_in.wake_time_ms   = csr_wdata;
            default:                     cfg_in = cfg_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.backlight_full <= kpe_pkg::RST_BACKLIGHT_FULL;
         cfg_ff.fade_per_ms    <= kpe_pkg::RST_FADE_PER_MS;
         cfg_ff.wake_time_ms   <= kpe_pkg::RST_WAKE_TIME_MS;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   assign cfg = cfg_ff;

endmodule

// ===== hw/rtl/kpe_in_stage.sv =====
// ----------------------------------------------------------------------------
// kpe_in_stage : input register
// Clamps the elapsed time and registers the fade product with the beat.
// ----------------------------------------------------------------------------
module kpe_in_stage (
   input  logic                            clock,
   input  logic                            reset,
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kpe_pkg::REQ_DATA_W-1:0]  req_tdata,
   input  logic [1:0]                      req_tuser,
   input  logic                            advance,
   input  logic [kpe_pkg::REG_W-1:0]       fade_per_ms,
   output logic                            item_valid,
   output kpe_pkg::item_type               item
);

   logic                  valid_ff, valid_in;
   kpe_pkg::item_type     item_ff, item_in;
   logic [kpe_pkg::EL_W-1:0] raw_elapsed;
   logic                  take;

   assign req_tready  = !valid_ff || advance;
   assign take        = req_tvalid && req_tready;
   assign raw_elapsed = req_tdata[kpe_pkg::KEY_W +: kpe_pkg::EL_W];

   always_comb begin
      item_in.op  = kpe_pkg::op_type'(req_tuser);
      item_in.key = req_tdata[kpe_pkg::KEY_W-1:0];
      // anything over the limit counts as the substitute value
      if (raw_elapsed > kpe_pkg::ELAPSED_LIMIT) begin
         item_in.elapsed = kpe_pkg::ELAPSED_SUBST;
      end else begin
         item_in.elapsed = raw_elapsed[kpe_pkg::E_W-1:0];
      end
      item_in.drop = kpe_pkg::DROP_W'(fade_per_ms) * kpe_pkg::DROP_W'(item_in.elapsed);
      valid_in = take ? 1'b1 : (advance ? 1'b0 : valid_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (take) begin
         item_ff <= item_in;
      end
   end

   assign item_valid = valid_ff;
   assign item       = item_ff;

endmodule

// ===== hw/rtl/kpe_core.sv =====
// ----------------------------------------------------------------------------
// kpe_core : entry state and result register
// State only moves when a result beat is loaded, so the state registers
// double as the result register.
// ----------------------------------------------------------------------------
module kpe_core #(
   parameter int PIN_MAX    = kpe_pkg::PIN_MAX_DEF,
   parameter int OPTION_MAX = kpe_pkg::OPTION_MAX_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  item_valid,
   input  kpe_pkg::item_type     item,
   input  kpe_pkg::cfg_type      cfg,
   input  logic                  rsp_tready,
   output logic                  rsp_tvalid,
   output logic                  advance,
   output kpe_pkg::result_type   result
);

   localparam int PCW = $clog2(PIN_MAX + 1);
   localparam int OCW = $clog2(OPTION_MAX + 1);

   kpe_pkg::mark_type   mode_ff, mode_in;
   logic [7:0]          pin_ff [PIN_MAX];
   logic [7:0]          pin_in [PIN_MAX];
   logic [PCW-1:0]      pin_used_ff, pin_used_in;
   logic [7:0]          opt_ff [OPTION_MAX];
   logic [7:0]          opt_in [OPTION_MAX];
   logic [OCW-1:0]      opt_used_ff, opt_used_in;
   logic [15:0]         count_ff, count_in;
   logic [15:0]         light_ff, light_in;
   logic                clear_ff, clear_in;
   logic                valid_ff, valid_in;

   logic                load;
   logic                clr_pin, clr_opt, add_pin, add_opt;
   logic [15:0]         e16, count_tick;
   logic [15:0]         pin_used_w;
   logic [15:0]         opt_used_w;

   assign advance = !valid_ff || rsp_tready;
   assign load    = advance && item_valid;
   assign e16     = 16'(item.elapsed);

   always_comb begin
      mode_in     = mode_ff;
      pin_used_in = pin_used_ff;
      opt_used_in = opt_used_ff;
      count_in    = count_ff;
      light_in    = light_ff;
      clear_in    = 1'b0;
      clr_pin     = 1'b0;
      clr_opt     = 1'b0;
      add_pin     = 1'b0;
      add_opt     = 1'b0;
      count_tick  = (count_ff > e16) ? (count_ff - e16) : 16'd0;

      unique case (item.op)
         kpe_pkg::OP_KEY: begin
            count_in = cfg.wake_time_ms;
            light_in = cfg.backlight_full;
            if (item.key == kpe_pkg::KEY_STAR) begin
               clr_pin = 1'b1;
               clr_opt = 1'b1;
               mode_in = kpe_pkg::MARK_STAR;
            end else if (mode_ff == kpe_pkg::MARK_HASH) begin
               if (item.key == kpe_pkg::KEY_HASH) begin
                  clr_pin = 1'b1;
                  clr_opt = 1'b1;
               end else if (opt_used_ff < OCW'(OPTION_MAX)) begin
                  add_opt     = 1'b1;
                  opt_used_in = opt_used_ff + OCW'(1);
                  if (opt_used_ff == OCW'(OPTION_MAX - 1)) begin
                     mode_in = kpe_pkg::MARK_STAR;
                  end
               end
            end else begin
               if (item.key == kpe_pkg::KEY_HASH) begin
                  mode_in = kpe_pkg::MARK_HASH;
                  clr_opt = 1'b1;
               end else if (pin_used_ff < PCW'(PIN_MAX)) begin
                  add_pin     = 1'b1;
                  pin_used_in = pin_used_ff + PCW'(1);
               end
            end
         end
         kpe_pkg::OP_TICK: begin
            count_in = count_tick;
            if (count_tick == 16'd0 && light_ff != 16'd0) begin
               clr_pin  = 1'b1;
               clr_opt  = 1'b1;
               mode_in  = kpe_pkg::MARK_NONE;
               clear_in = 1'b1;
               if (item.drop >= kpe_pkg::DROP_W'(light_ff)) begin
                  light_in = 16'd0;
               end else begin
                  light_in = light_ff - item.drop[15:0];
               end
            end
         end
         kpe_pkg::OP_WAKE: begin
            count_in = cfg.wake_time_ms;
            light_in = cfg.backlight_full;
         end
         kpe_pkg::OP_SLEEP: begin
            count_in = 16'd0;
         end
         default: begin
            count_in = count_ff;
         end
      endcase

      if (clr_pin) pin_used_in = '0;
      if (clr_opt) opt_used_in = '0;

      for (int i = 0; i < PIN_MAX; i++) begin
         if (clr_pin) begin
            pin_in[i] = 8'd0;
         end else if (add_pin && pin_used_ff == PCW'(i)) begin
            pin_in[i] = item.key;
         end else begin
            pin_in[i] = pin_ff[i];
         end
      end
      for (int i = 0; i < OPTION_MAX; i++) begin
         if (clr_opt) begin
            opt_in[i] = 8'd0;
         end else if (add_opt && opt_used_ff == OCW'(i)) begin
            opt_in[i] = item.key;
         end else begin
            opt_in[i] = opt_ff[i];
         end
      end

      valid_in = advance ? item_valid : valid_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff    <= 1'b0;
         mode_ff     <= kpe_pkg::MARK_NONE;
         pin_used_ff <= '0;
         opt_used_ff <= '0;
         count_ff    <= 16'd0;
         light_ff    <= 16'd0;
         clear_ff    <= 1'b0;
         for (int i = 0; i < PIN_MAX; i++) pin_ff[i] <= 8'd0;
         for (int i = 0; i < OPTION_MAX; i++) opt_ff[i] <= 8'd0;
      end else begin
         valid_ff <= valid_in;
         if (load) begin
            mode_ff     <= mode_in;
            pin_used_ff <= pin_used_in;
            opt_used_ff <= opt_used_in;
            count_ff    <= count_in;
            light_ff    <= light_in;
            clear_ff    <= clear_in;
            for (int i = 0; i < PIN_MAX; i++) pin_ff[i] <= pin_in[i];
            for (int i = 0; i < OPTION_MAX; i++) opt_ff[i] <= opt_in[i];
         end
      end
   end

   // result view of the state
   assign pin_used_w = 16'(pin_used_ff);
   assign opt_used_w = 16'(opt_used_ff);

   for (genvar g = 0; g < 8; g++) begin : g_head
      if (g < PIN_MAX) begin : g_on
         assign result.pin_head[8*g +: 8] = pin_ff[g];
      end else begin : g_off
         assign result.pin_head[8*g +: 8] = 8'd0;
      end
   end
   for (genvar g = 0; g < 2; g++) begin : g_tail
      if (g + 8 < PIN_MAX) begin : g_on
         assign result.pin_tail[8*g +: 8] = pin_ff[g + 8];
      end else begin : g_off
         assign result.pin_tail[8*g +: 8] = 8'd0;
      end
   end
   for (genvar g = 0; g < 3; g++) begin : g_opt
      if (g < OPTION_MAX) begin : g_on
         assign result.option_code[8*g +: 8] = opt_ff[g];
      end else begin : g_off
         assign result.option_code[8*g +: 8] = 8'd0;
      end
   end

   assign result.entry_mode    = mode_ff;
   assign result.pin_count     = pin_used_w[3:0];
   assign result.option_count  = opt_used_w[1:0];
   assign result.backlight     = light_ff;
   assign result.awake_left_ms = count_ff;
   assign result.sleep_clear   = clear_ff;
   assign rsp_tvalid           = valid_ff;

endmodule

// ===== hw/rtl/keypad_entry_with_autosleep.sv =====
// ----------------------------------------------------------------------------
// keypad_entry_with_autosleep : door keypad front end with autosleep
// Gathers a PIN and an option code from key beats, runs the autosleep
// countdown from tick beats and fades the backlight once asleep.
// ----------------------------------------------------------------------------
//
// channel   dir  handshake            payload
// req_      in   tvalid/tready        tdata: key_char, elapsed_ms; tuser: operation
// rsp_      out  tvalid/tready        tdata: entry_mode .. sleep_clear
// csr_      in   we (no wait)         addr: register index, wdata: value
//
// One result beat per request beat: the input register clamps the elapsed time
// and forms the fade product, and the state register, which doubles as the
// result register, is then updated from it.
// Sustained rate is one beat per cycle; a stalled result beat holds the
// pipeline, and the input register still takes one beat meanwhile.
// Reset (synchronous) clears the entry, the countdown and the backlight and
// loads the register defaults: full level 4095, fade 4 per ms, wake 5000 ms.
// The user must write registers only while no beat is in flight; not enforced.
// ----------------------------------------------------------------------------
module keypad_entry_with_autosleep #(
   parameter int PIN_MAX    = kpe_pkg::PIN_MAX_DEF,
   parameter int OPTION_MAX = kpe_pkg::OPTION_MAX_DEF
) (
   input  logic                            clock,
   input  logic                            reset,
   // request: tdata [7:0] key_char, [23:8] elapsed_ms
   input  logic                            req_tvalid,
   output logic                            req_tready,
   input  logic [kpe_pkg::REQ_DATA_W-1:0]  req_tdata,
   // request: tuser [1:0] operation
   input  logic [1:0]                      req_tuser,
   // result: tdata [1:0] entry_mode, [65:2] pin_head, [81:66] pin_tail,
   // [85:82] pin_count, [109:86] option_code, [111:110] option_count,
   // [127:112] backlight, [143:128] awake_left_ms, [144] sleep_clear,
   // [151:145] zero
   output logic                            rsp_tvalid,
   input  logic                            rsp_tready,
   output logic [kpe_pkg::RSP_DATA_W-1:0]  rsp_tdata,
   // configuration
   input  logic                            csr_we,
   input  logic [kpe_pkg::CSR_A_W-1:0]     csr_addr,
   input  logic [kpe_pkg::REG_W-1:0]       csr_wdata
);

   kpe_pkg::cfg_type     cfg;
   kpe_pkg::item_type    item;
   kpe_pkg::result_type  result;
   logic                 item_valid;
   logic                 advance;

   kpe_csr u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_we    (csr_we),
      .csr_addr  (csr_addr),
      .csr_wdata (csr_wdata),
      .cfg       (cfg)
   );

   // input register: clamp and fade product
   kpe_in_stage u_in (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .advance     (advance),
      .fade_per_ms (cfg.fade_per_ms),
      .item_valid  (item_valid),
      .item        (item)
   );

   // entry state, countdown and backlight; loads the result beat
   kpe_core #(
      .PIN_MAX    (PIN_MAX),
      .OPTION_MAX (OPTION_MAX)
   ) u_core (
      .clock      (clock),
      .reset      (reset),
      .item_valid (item_valid),
      .item       (item),
      .cfg        (cfg),
      .rsp_tready (rsp_tready),
      .rsp_tvalid (rsp_tvalid),
      .advance    (advance),
      .result     (result)
   );

   // pad the packed result out to whole bytes
   assign rsp_tdata = {{(kpe_pkg::RSP_DATA_W - kpe_pkg::RESULT_W){1'b0}}, result};

endmodule

// ===== hw/rtl/kpe_checker.sv =====
// ----------------------------------------------------------------------------
// kpe_checker : port-level checks for the keypad entry block
// Watches the handshakes and result fields; bound to the top level.
// ----------------------------------------------------------------------------
module kpe_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_tvalid,
   input logic                            req_tready,
   input logic                            rsp_tvalid,
   input logic                            rsp_tready,
   input logic [kpe_pkg::RSP_DATA_W-1:0]  rsp_tdata
);

   // a stalled result beat holds
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata))
      else $error("result beat changed while stalled");

   // every accepted request is followed by a valid result beat
   a_latency: assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |-> ##2 rsp_tvalid)
      else $error("accepted request produced no result beat");

   // a sleep clear leaves an empty entry and a spent countdown
   a_sleep_clear: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tdata[144] |->
         rsp_tdata[1:0] == 2'd0 && rsp_tdata[85:82] == 4'd0 &&
         rsp_tdata[111:110] == 2'd0 && rsp_tdata[143:128] == 16'd0)
      else $error("sleep clear with entry or countdown left");

   // nothing comes out straight after reset
   a_reset_quiet: assert property (@(posedge clock)
      $past(reset) |-> !rsp_tvalid)
      else $error("result beat right after reset");

endmodule

bind keypad_entry_with_autosleep kpe_checker u_kpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata)
);
